FILE: hw/rtl/slir_pkg.sv
// ----------------------------------------------------------------------------
// slir_pkg
// Shared types, constants and the interpolation function of the resampler.
// ----------------------------------------------------------------------------
package slir_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 16;
    localparam int MAX_RUN     = 8;

    localparam int PHASE_W     = 20;
    localparam int COUNT_W     = 24;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int RUN_W       = $clog2(MAX_RUN + 1);
    localparam int CMDQ_DEPTH  = 2;
    localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);
    localparam int PROD_W      = SAMPLE_BITS + FRAC_BITS + 2;

    localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << FRAC_BITS;

    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_STEREO_MODE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_FRAMES = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_CNT  = CFG_IDX_W'(3);

    localparam logic [PHASE_W-1:0] PHASE_STEP_RST = PHASE_W'(65536);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase_step;
        logic               stereo_mode;
        logic [COUNT_W-1:0] skip_frames;
        logic [COUNT_W-1:0] output_count;
    } cfg_t;

    typedef struct packed {
        logic    interp;
        logic    eos;
        sample_t s0_left;
        sample_t s0_right;
        sample_t s1_left;
        sample_t s1_right;
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } back_state_t;

    function automatic sample_t lerp(sample_t s0, sample_t s1, logic [FRAC_BITS-1:0] frac);
        logic signed [SAMPLE_BITS:0]   diff;
        logic signed [PROD_W-1:0]      prod;
        logic signed [PROD_W-1:0]      shifted;
        diff    = {s1[SAMPLE_BITS-1], s1} - {s0[SAMPLE_BITS-1], s0};
        prod    = PROD_W'(diff) * $signed(PROD_W'({1'b0, frac}));
        shifted = prod >>> FRAC_BITS;
        return s0 + sample_t'(shifted[SAMPLE_BITS-1:0]);
    endfunction

endpackage

FILE: hw/rtl/slir_front.sv
// ----------------------------------------------------------------------------
// slir_front
// Accepts source frames, drops skipped frames, keeps the previous frame and
// queues interpolation and clear commands for the back end.
// ----------------------------------------------------------------------------
module slir_front (
    input  logic             clk,
    input  logic             rst_n,
    input  slir_pkg::cfg_t   cfg,
    input  logic             push,
    output logic             full,
    input  slir_pkg::sample_t left_in,
    input  slir_pkg::sample_t right_in,
    input  logic             end_of_source,
    output logic             q_push,
    output slir_pkg::cmd_t   q_data,
    input  logic             q_full
);
    import slir_pkg::*;

    logic [COUNT_W-1:0] frames_seen_reg, frames_seen_next;
    logic               have_prev_reg, have_prev_next;
    sample_t            prev_left_reg, prev_left_next;
    sample_t            prev_right_reg, prev_right_next;
    logic               accept;
    logic               is_skip;
    logic               is_interp;

    assign full      = q_full;
    assign accept    = push && !q_full;
    assign is_skip   = frames_seen_reg < cfg.skip_frames;
    assign is_interp = !is_skip && have_prev_reg;

    assign q_push          = accept && (is_interp || end_of_source);
    assign q_data.interp   = is_interp;
    assign q_data.eos      = end_of_source;
    assign q_data.s0_left  = prev_left_reg;
    assign q_data.s0_right = prev_right_reg;
    assign q_data.s1_left  = left_in;
    assign q_data.s1_right = right_in;

    always_comb
    begin
        frames_seen_next = frames_seen_reg;
        have_prev_next   = have_prev_reg;
        prev_left_next   = prev_left_reg;
        prev_right_next  = prev_right_reg;
        if (accept)
        begin
            if (end_of_source)
            begin
                frames_seen_next = '0;
                have_prev_next   = 1'b0;
            end
            else if (is_skip)
            begin
                frames_seen_next = frames_seen_reg + COUNT_W'(1);
            end
            else
            begin
                have_prev_next  = 1'b1;
                prev_left_next  = left_in;
                prev_right_next = right_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_seen_reg <= '0;
            have_prev_reg   <= 1'b0;
        end
        else
        begin
            frames_seen_reg <= frames_seen_next;
            have_prev_reg   <= have_prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_left_reg  <= prev_left_next;
        prev_right_reg <= prev_right_next;
    end

endmodule

FILE: hw/rtl/slir_cmd_fifo.sv
// ----------------------------------------------------------------------------
// slir_cmd_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module slir_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  slir_pkg::cmd_t wr_data,
    output logic           full,
    input  logic           pop,
    output slir_pkg::cmd_t rd_data,
    output logic           empty
);
    import slir_pkg::*;

    cmd_t                  mem_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  do_push;
    logic                  do_pop;

    assign full    = cnt_reg == CMDQ_CNT_W'(CMDQ_DEPTH);
    assign empty   = cnt_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: hw/rtl/slir_back.sv
// ----------------------------------------------------------------------------
// slir_back
// Runs the phase loop for each queued frame pair and emits one interpolated
// word per cycle into the output register while that register is free.
// ----------------------------------------------------------------------------
module slir_back (
    input  logic              clk,
    input  logic              rst_n,
    input  slir_pkg::cfg_t    cfg,
    input  slir_pkg::cmd_t    q_data,
    input  logic              q_empty,
    output logic              q_pop,
    output logic              empty,
    input  logic              pop,
    output slir_pkg::sample_t left_out,
    output slir_pkg::sample_t right_out,
    output logic              run_last,
    output logic              count_done
);
    import slir_pkg::*;

    back_state_t        state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [PHASE_W:0]   phase_acc_reg, phase_acc_next;
    logic [COUNT_W-1:0] outputs_made_reg, outputs_made_next;
    logic [RUN_W-1:0]   run_cnt_reg, run_cnt_next;
    logic               out_valid_reg, out_valid_next;
    sample_t            out_left_reg, out_left_next;
    sample_t            out_right_reg, out_right_next;
    logic               out_last_reg, out_last_next;
    logic               out_done_reg, out_done_next;

    logic               out_free;
    logic               cont;
    logic               emit;
    logic               finish;
    logic [PHASE_W:0]   phase_sum;
    logic [COUNT_W:0]   made_inc;
    sample_t            lerp_left;
    sample_t            lerp_right;

    assign out_free  = !out_valid_reg || pop;
    assign phase_sum = phase_acc_reg + {1'b0, cfg.phase_step};
    assign made_inc  = {1'b0, outputs_made_reg} + (COUNT_W + 1)'(1);
    assign cont      = (run_cnt_reg < RUN_W'(MAX_RUN)) && (phase_acc_reg < {1'b0, PHASE_ONE})
                       && (outputs_made_reg < cfg.output_count);
    assign lerp_left  = lerp(cmd_reg.s0_left, cmd_reg.s1_left, phase_acc_reg[FRAC_BITS-1:0]);
    assign lerp_right = lerp(cmd_reg.s0_right, cmd_reg.s1_right,
                             phase_acc_reg[FRAC_BITS-1:0]);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty && q_data.interp)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (!cont)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        q_pop  = 1'b0;
        emit   = 1'b0;
        finish = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                q_pop = !q_empty;
            end
            ST_RUN:
            begin
                emit   = cont && out_free;
                finish = !cont;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        cmd_next          = cmd_reg;
        phase_acc_next    = phase_acc_reg;
        outputs_made_next = outputs_made_reg;
        run_cnt_next      = run_cnt_reg;
        out_valid_next    = out_valid_reg && !pop;
        out_left_next     = out_left_reg;
        out_right_next    = out_right_reg;
        out_last_next     = out_last_reg;
        out_done_next     = out_done_reg;
        if (q_pop)
        begin
            cmd_next     = q_data;
            run_cnt_next = '0;
            if (!q_data.interp && q_data.eos)
            begin
                phase_acc_next    = '0;
                outputs_made_next = '0;
            end
        end
        if (emit)
        begin
            phase_acc_next    = phase_sum;
            outputs_made_next = made_inc[COUNT_W-1:0];
            run_cnt_next      = run_cnt_reg + RUN_W'(1);
            out_valid_next    = 1'b1;
            out_left_next     = lerp_left;
            out_right_next    = cfg.stereo_mode ? lerp_right : lerp_left;
            out_last_next     = !((run_cnt_reg < RUN_W'(MAX_RUN - 1))
                                  && (phase_sum < {1'b0, PHASE_ONE})
                                  && (made_inc < {1'b0, cfg.output_count}));
            out_done_next     = made_inc == {1'b0, cfg.output_count};
        end
        if (finish)
        begin
            if (cmd_reg.eos)
            begin
                phase_acc_next    = '0;
                outputs_made_next = '0;
            end
            else if (phase_acc_reg >= {1'b0, PHASE_ONE})
            begin
                phase_acc_next = phase_acc_reg - {1'b0, PHASE_ONE};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            phase_acc_reg    <= '0;
            outputs_made_reg <= '0;
            run_cnt_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            phase_acc_reg    <= phase_acc_next;
            outputs_made_reg <= outputs_made_next;
            run_cnt_reg      <= run_cnt_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        out_left_reg  <= out_left_next;
        out_right_reg <= out_right_next;
        out_last_reg  <= out_last_next;
        out_done_reg  <= out_done_next;
    end

    assign empty      = !out_valid_reg;
    assign left_out   = out_left_reg;
    assign right_out  = out_right_reg;
    assign run_last   = out_last_reg;
    assign count_done = out_done_reg;

`ifndef SYNTHESIS
    a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (run_cnt_reg <= RUN_W'(MAX_RUN)))
        else $error("run counter beyond limit");

    a_eos_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && cmd_reg.eos) |=> (phase_acc_reg == '0 && outputs_made_reg == '0))
        else $error("state not cleared after end of source");

    a_count_done: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && made_inc == {1'b0, cfg.output_count})
        |=> (count_done && outputs_made_reg == cfg.output_count))
        else $error("count_done does not match output count");

    a_no_emit_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |-> !emit)
        else $error("word emitted over a waiting word");
`endif

endmodule

FILE: hw/rtl/stereo_linear_interp_resampler_unit.sv
// ----------------------------------------------------------------------------
// stereo_linear_interp_resampler_unit
// Stereo linear interpolation sample-rate converter with skip and count limit.
// ----------------------------------------------------------------------------
// path: an accepted frame goes into the command queue, then into the back end's
//   command register, and its first word is registered in the output register
// throughput: one word per cycle while the receiver keeps popping; a frame
//   gives at most MAX_RUN words and the next queued frame waits until its run ends
// reset: asynchronous, clears the frame control state and loads register defaults
module stereo_linear_interp_resampler_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [slir_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [slir_pkg::CFG_DATA_W-1:0]     wr_data,
    input  logic                                push,
    output logic                                full,
    input  slir_pkg::sample_t                   left_in,
    input  slir_pkg::sample_t                   right_in,
    input  logic                                end_of_source,
    output logic                                empty,
    input  logic                                pop,
    output slir_pkg::sample_t                   left_out,
    output slir_pkg::sample_t                   right_out,
    output logic                                run_last,
    output logic                                count_done
);
    import slir_pkg::*;

    cfg_t cfg_reg, cfg_next;
    cmd_t front_cmd;
    cmd_t back_cmd;
    logic front_push;
    logic q_full;
    logic q_empty;
    logic q_pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_PHASE_STEP:  cfg_next.phase_step   = wr_data[PHASE_W-1:0];
                REG_STEREO_MODE: cfg_next.stereo_mode  = wr_data[0];
                REG_SKIP_FRAMES: cfg_next.skip_frames  = wr_data[COUNT_W-1:0];
                REG_OUTPUT_CNT:  cfg_next.output_count = wr_data[COUNT_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_step   <= PHASE_STEP_RST;
            cfg_reg.stereo_mode  <= 1'b1;
            cfg_reg.skip_frames  <= '0;
            cfg_reg.output_count <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    slir_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .push          (push),
        .full          (full),
        .left_in       (left_in),
        .right_in      (right_in),
        .end_of_source (end_of_source),
        .q_push        (front_push),
        .q_data        (front_cmd),
        .q_full        (q_full)
    );

    slir_cmd_fifo u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (front_push),
        .wr_data (front_cmd),
        .full    (q_full),
        .pop     (q_pop),
        .rd_data (back_cmd),
        .empty   (q_empty)
    );

    slir_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_data     (back_cmd),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .left_out   (left_out),
        .right_out  (right_out),
        .run_last   (run_last),
        .count_done (count_done)
    );

endmodule

FILE: verif/resampler_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resampler_check_pkg
// Scoreboard for the stereo resampler: keeps its own copy of the registers
// and frame state, predicts the interpolated words of every accepted frame
// and compares the words popped from the block against them in order.
// ----------------------------------------------------------------------------
package resampler_check_pkg;

    import slir_pkg::*;

    localparam longint unsigned UNIT_PHASE = longint'(1) << FRAC_BITS;
    localparam int              REPORT_MAX = 10;

    typedef struct packed {
        sample_t left;
        sample_t right;
        logic    last;
        logic    done;
    } resample_word_t;

    class resample_scoreboard;

        int unsigned       phase_step   = PHASE_STEP_RST;
        bit                stereo_mode  = 1'b1;
        int unsigned       skip_frames  = 0;
        int unsigned       output_count = 0;

        sample_t           prev_left    = '0;
        sample_t           prev_right   = '0;
        bit                have_prev    = 1'b0;
        longint unsigned   phase_acc    = 0;
        int unsigned       frames_seen  = 0;
        int unsigned       outputs_made = 0;

        resample_word_t    expected_words[$];
        int                mismatches    = 0;
        int                words_checked = 0;

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_PHASE_STEP:  phase_step   = value[PHASE_W-1:0];
                REG_STEREO_MODE: stereo_mode  = value[0];
                REG_SKIP_FRAMES: skip_frames  = value[COUNT_W-1:0];
                REG_OUTPUT_CNT:  output_count = value[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        // floor division by the phase unit, result always between a and b
        function sample_t interp(sample_t a, sample_t b, longint unsigned frac);
            longint prod;
            prod = (longint'(b) - longint'(a)) * longint'(frac);
            return sample_t'(longint'(a) + (prod >>> FRAC_BITS));
        endfunction

        function void note_frame(sample_t l, sample_t r, logic eos);
            int              n;
            longint unsigned ph;
            resample_word_t  w;
            n = 0;
            if (frames_seen < skip_frames) begin
                frames_seen++;
            end
            else if (!have_prev) begin
                prev_left  = l;
                prev_right = r;
                have_prev  = 1'b1;
            end
            else begin
                ph = phase_acc;
                while (n < MAX_RUN && ph < UNIT_PHASE && outputs_made < output_count) begin
                    w.left  = interp(prev_left, l, ph);
                    w.right = stereo_mode ? interp(prev_right, r, ph) : w.left;
                    outputs_made++;
                    w.last  = 1'b0;
                    w.done  = (outputs_made == output_count);
                    expected_words.push_back(w);
                    ph += phase_step;
                    n++;
                end
                if (ph >= UNIT_PHASE) begin
                    ph -= UNIT_PHASE;
                end
                phase_acc  = ph;
                prev_left  = l;
                prev_right = r;
            end
            if (n > 0) begin
                expected_words[expected_words.size() - 1].last = 1'b1;
            end
            if (eos) begin
                prev_left    = '0;
                prev_right   = '0;
                have_prev    = 1'b0;
                phase_acc    = 0;
                frames_seen  = 0;
                outputs_made = 0;
            end
        endfunction

        function void check_word(sample_t l, sample_t r, logic last, logic done);
            resample_word_t w;
            words_checked++;
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("[%0t] unexpected word: L=%0d R=%0d last=%b done=%b",
                             $time, l, r, last, done);
                end
                return;
            end
            w = expected_words.pop_front();
            if (w.left !== l || w.right !== r || w.last !== last || w.done !== done) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("[%0t] word mismatch: expected L=%0d R=%0d last=%b done=%b",
                             $time, w.left, w.right, w.last, w.done);
                    $display("[%0t]                  actual L=%0d R=%0d last=%b done=%b",
                             $time, l, r, last, done);
                end
            end
        endfunction

    endclass

endpackage

FILE: verif/stereo_linear_interp_resampler_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_linear_interp_resampler_unit_tb
// Drives source frames through the push/full side and pops interpolated words
// with random gaps on both sides, after a directed set of corner frames. Each
// phase writes all four registers while the block is idle; every popped word
// is checked against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module stereo_linear_interp_resampler_unit_tb;

    import slir_pkg::*;
    import resampler_check_pkg::*;

    localparam int RANDOM_FRAMES = 125;
    localparam int DRAIN_CYCLES  = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int LIMIT_CYCLES  = 500000;

    logic                   clk;
    logic                   rst_n         = 1'b0;
    logic                   wr_en         = 1'b0;
    logic [CFG_IDX_W-1:0]   wr_index      = '0;
    logic [CFG_DATA_W-1:0]  wr_data       = '0;
    logic                   push          = 1'b0;
    logic                   full;
    sample_t                left_in       = '0;
    sample_t                right_in      = '0;
    logic                   end_of_source = 1'b0;
    logic                   empty;
    logic                   pop           = 1'b0;
    sample_t                left_out;
    sample_t                right_out;
    logic                   run_last;
    logic                   count_done;

    resample_scoreboard     sb;
    bit                     sender_steady = 1'b0;
    logic                   hold_req      = 1'b0;
    bit                     hold_done     = 1'b0;
    bit                     saw_full      = 1'b0;
    bit                     took;
    int                     hold_left     = 0;
    int                     pop_gap       = 0;
    int                     burst_left    = 0;
    int                     frames_sent   = 0;
    int                     phases_run    = 0;
    int                     cycle_count   = 0;

    sample_t corner_left  [7] = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh7FFF,
                                  16'sh8000, 16'sh0001, 16'shFFFF};
    sample_t corner_right [7] = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh7FFF,
                                  16'sh8000, 16'shFFFF, 16'sh0001};

    stereo_linear_interp_resampler_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data),
        .push          (push),
        .full          (full),
        .left_in       (left_in),
        .right_in      (right_in),
        .end_of_source (end_of_source),
        .empty         (empty),
        .pop           (pop),
        .left_out      (left_out),
        .right_out     (right_out),
        .run_last      (run_last),
        .count_done    (count_done)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic sample_t rand_sample();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return sample_t'($urandom_range(0, 7) - 4);
            default: return sample_t'($urandom);
        endcase
    endfunction

    task automatic send_frame(sample_t l, sample_t r, logic eos);
        int gap;
        gap = sender_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push          <= 1'b1;
        left_in       <= l;
        right_in      <= r;
        end_of_source <= eos;
        @(posedge clk);
        while (full) @(posedge clk);
        sb.note_frame(l, r, eos);
        frames_sent++;
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (sb.expected_words.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value;
        @(posedge clk);
        sb.set_reg(idx, value);
    endtask

    task automatic configure(int unsigned step, bit stereo, int unsigned skip,
                             int unsigned count);
        wait_idle();
        write_reg(REG_PHASE_STEP,  CFG_DATA_W'(step));
        write_reg(REG_STEREO_MODE, CFG_DATA_W'(stereo));
        write_reg(REG_SKIP_FRAMES, CFG_DATA_W'(skip));
        write_reg(REG_OUTPUT_CNT,  CFG_DATA_W'(count));
        wr_en <= 1'b0;
    endtask

    task automatic run_phase(int unsigned step, bit stereo, int unsigned skip,
                             int unsigned count, int n, bit hold);
        logic eos;
        configure(step, stereo, skip, count);
        if (hold)
        begin
            hold_req <= 1'b1;
        end
        for (int i = 0; i < n; i++)
        begin
            eos = (i == n - 1) ? 1'b1 : ($urandom_range(0, 19) == 0);
            send_frame(rand_sample(), rand_sample(), eos);
        end
        phases_run++;
    endtask

    // receiver: random pop gaps, occasional steady bursts, one long hold-off
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            took = 1'b0;
            if (pop && !empty)
            begin
                sb.check_word(left_out, right_out, run_last, count_done);
                took = 1'b1;
            end
            if (hold_left == 0 && hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0 && full)
            begin
                saw_full = 1'b1;
            end
            if (burst_left > 0)
            begin
                burst_left--;
            end
            else if ($urandom_range(0, 199) == 0)
            begin
                burst_left = 120;
            end
            if (took && burst_left == 0 && pop_gap == 0)
            begin
                pop_gap = pick_gap();
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (pop_gap > 0)
            begin
                pop_gap--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_count, sb.expected_words.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        int unsigned cfg_step;
        int unsigned cfg_skip;
        int unsigned cfg_count;
        bit          cfg_stereo;
        int          n;
        int          r;
        int          random_frames;
        int          phase_no;

        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full-scale swings at half step, floor on negative slopes
        configure(32'h8000, 1'b1, 0, 24'hFFFFFF);
        for (int i = 0; i < 7; i++)
        begin
            send_frame(corner_left[i], corner_right[i], i == 6);
        end
        phases_run++;
        // mono, skipped leading frames, count reached mid stream
        run_phase(32'h18000, 1'b0, 2, 5, 10, 1'b0);
        // step below 1/8: run limit cuts each interval
        run_phase(5000, 1'b1, 0, 24'hFFFFFF, 3, 1'b0);
        // zero step: every frame gives a full run until the count stops it
        run_phase(0, 1'b1, 0, 20, 4, 1'b0);
        // largest skip with zero count, cleared by end of source
        run_phase(32'h80000, 1'b0, 24'hFFFFFF, 0, 1, 1'b0);

        random_frames = 0;
        phase_no      = 0;
        while (random_frames < RANDOM_FRAMES)
        begin
            if (phase_no == 2)
            begin
                sender_steady = 1'b1;
                run_phase(8192, 1'b1, 0, 24'hFFFFFF, 20, 1'b1);
                random_frames += 20;
            end
            else
            begin
                r = $urandom_range(0, 19);
                case (r)
                    0:       cfg_step = 0;
                    1:       cfg_step = 8192;
                    2:       cfg_step = 524288;
                    3:       cfg_step = 20'hFFFFF;
                    4:       cfg_step = $urandom_range(1, 8191);
                    5:       cfg_step = 65536;
                    default: cfg_step = $urandom_range(8192, 524288);
                endcase
                cfg_stereo = $urandom_range(0, 1);
                r = $urandom_range(0, 9);
                cfg_skip = (r < 6) ? 0 : (r < 9) ? $urandom_range(1, 4) : $urandom_range(5, 30);
                r = $urandom_range(0, 9);
                cfg_count = (r == 0) ? 0 : (r < 4) ? $urandom_range(1, 30) : 24'hFFFFFF;
                n = $urandom_range(4, 20);
                sender_steady = ($urandom_range(0, 3) == 0);
                run_phase(cfg_step, cfg_stereo, cfg_skip, cfg_count, n, 1'b0);
                random_frames += n;
            end
            phase_no++;
        end

        wait_idle();
        $display("%0d frames in %0d register settings, %0d words checked, %0d mismatches",
                 frames_sent, phases_run, sb.words_checked, sb.mismatches);
        $display("long receiver hold-off %s the input side",
                 saw_full ? "backed up" : "did not back up");
        if (sb.mismatches == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
